@@ rtl/core/rvx_pkg.sv @@
package rvx_pkg;

  localparam int NUM_REGS  = 32;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int XLEN      = 64;

  typedef logic [XLEN-1:0]      xlen_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_EXEC  = 1'b1;

  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SRL = 3'd5;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;

  localparam reg_idx_t REG_ZERO = reg_idx_t'(0);
  localparam reg_idx_t REG_SP   = reg_idx_t'(2);
  localparam reg_idx_t REG_A0   = reg_idx_t'(10);
  localparam reg_idx_t REG_A1   = reg_idx_t'(11);
  localparam reg_idx_t REG_A2   = reg_idx_t'(12);
  localparam reg_idx_t REG_A3   = reg_idx_t'(13);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADOP   = 2'd1;
  localparam logic [1:0] ST_BADFUNC = 2'd2;

  // register write request from the execute stage
  typedef struct packed {
    logic     en;
    reg_idx_t addr;
    xlen_t    data;
  } rf_wr_t;

  // register values right after a start transfer
  typedef struct packed {
    xlen_t sp;
    xlen_t a0;
    xlen_t a1;
    xlen_t a2;
    xlen_t a3;
  } rf_init_t;

  typedef struct packed {
    logic       is_mul;
    logic       wr_en;
    xlen_t      wr_data;
    xlen_t      next_pc;
    logic [1:0] status;
  } alu_res_t;

endpackage

@@ rtl/core/rvx_regfile.sv @@
module rvx_regfile
  import rvx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rd_en,
  input  reg_idx_t raddr1,
  input  reg_idx_t raddr2,
  input  rf_wr_t   wr,
  input  logic     start,
  input  rf_init_t init,
  output xlen_t    rdata1,
  output xlen_t    rdata2
);

  xlen_t           mem [NUM_REGS];
  xlen_t           q1_r, q2_r;
  reg_idx_t        ra1_r, ra2_r;
  logic [NUM_REGS-1:0] valid_r, valid_nxt;
  rf_init_t        init_r;
  logic            wb_en_r;
  reg_idx_t        wb_addr_r;
  xlen_t           wb_data_r;
  logic            wr_ok;

  assign wr_ok = wr.en && (wr.addr != REG_ZERO);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q1_r  <= mem[raddr1];
      q2_r  <= mem[raddr2];
      ra1_r <= raddr1;
      ra2_r <= raddr2;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (start) begin
      valid_nxt = '0;
    end else if (wr_ok) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  // last write is forwarded: a read issued on the same edge sees old memory data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      init_r  <= '0;
      wb_en_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (start) begin
        init_r  <= init;
        wb_en_r <= 1'b0;
      end else if (wr_ok) begin
        wb_en_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      wb_addr_r <= wr.addr;
      wb_data_r <= wr.data;
    end
  end

  function automatic xlen_t init_val(reg_idx_t a, rf_init_t iv);
    xlen_t v;
    case (a)
      REG_SP:  v = iv.sp;
      REG_A0:  v = iv.a0;
      REG_A1:  v = iv.a1;
      REG_A2:  v = iv.a2;
      REG_A3:  v = iv.a3;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    if (wb_en_r && (wb_addr_r == ra1_r)) begin
      rdata1 = wb_data_r;
    end else if (valid_r[ra1_r]) begin
      rdata1 = q1_r;
    end else begin
      rdata1 = init_val(ra1_r, init_r);
    end
    if (wb_en_r && (wb_addr_r == ra2_r)) begin
      rdata2 = wb_data_r;
    end else if (valid_r[ra2_r]) begin
      rdata2 = q2_r;
    end else begin
      rdata2 = init_val(ra2_r, init_r);
    end
  end

endmodule

@@ rtl/core/rvx_mul.sv @@
module rvx_mul
  import rvx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  logic  clr,
  input  xlen_t a,
  input  xlen_t b,
  output logic  done,
  output xlen_t prod
);

  localparam int HALF = XLEN / 2;
  localparam logic [1:0] STEP_LL   = 2'd0;
  localparam logic [1:0] STEP_LH   = 2'd1;
  localparam logic [1:0] STEP_HL   = 2'd2;
  localparam logic [1:0] STEP_DONE = 2'd3;

  logic [1:0]      step_r, step_nxt;
  xlen_t           acc_r;
  logic [HALF-1:0] op_a, op_b;
  xlen_t           p;

  // low 64 bits only: lo*lo, then the two cross terms shifted up
  always_comb begin
    case (step_r)
      STEP_LL: begin
        op_a = a[HALF-1:0];
        op_b = b[HALF-1:0];
      end
      STEP_LH: begin
        op_a = a[HALF-1:0];
        op_b = b[XLEN-1:HALF];
      end
      default: begin
        op_a = a[XLEN-1:HALF];
        op_b = b[HALF-1:0];
      end
    endcase
  end

  assign p = {{HALF{1'b0}}, op_a} * {{HALF{1'b0}}, op_b};

  always_comb begin
    step_nxt = step_r;
    if (clr) begin
      step_nxt = STEP_LL;
    end else if (go && (step_r != STEP_DONE)) begin
      step_nxt = step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LL;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (step_r != STEP_DONE)) begin
      if (step_r == STEP_LL) begin
        acc_r <= p;
      end else begin
        acc_r <= acc_r + {p[HALF-1:0], {HALF{1'b0}}};
      end
    end
  end

  assign done = (step_r == STEP_DONE);
  assign prod = acc_r;

endmodule

@@ rtl/core/rvx_alu.sv @@
module rvx_alu
  import rvx_pkg::*;
(
  input  logic [31:0] instr,
  input  xlen_t       x,
  input  xlen_t       y,
  input  xlen_t       pc,
  input  xlen_t       mul_prod,
  output alu_res_t    res
);

  logic [6:0] op, f7;
  logic [2:0] f3;
  xlen_t      imm_i, off_b, off_j, pc4;
  logic       take;

  assign op = instr[6:0];
  assign f3 = instr[14:12];
  assign f7 = instr[31:25];
  assign pc4 = pc + 64'd4;

  assign imm_i = {{52{instr[31]}}, instr[31:20]};
  assign off_b = {{51{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign off_j = {{43{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

  always_comb begin
    res = '0;
    res.next_pc = pc;
    res.status  = ST_OK;
    take = 1'b0;
    case (op)
      OP_REG: begin
        res.wr_en   = 1'b1;
        res.next_pc = pc4;
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          res.wr_data = x + y;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          res.wr_data = x - y;
        end else if (f3 == F3_ADD && f7 == F7_MULDIV) begin
          res.is_mul  = 1'b1;
          res.wr_data = mul_prod;
        end else if (f3 == F3_AND && f7 == F7_BASE) begin
          res.wr_data = x & y;
        end else if (f3 == F3_SLL && f7 == F7_BASE) begin
          res.wr_data = x << y[5:0];
        end else if (f3 == F3_SRL && f7 == F7_BASE) begin
          res.wr_data = x >> y[5:0];
        end else begin
          res.wr_en   = 1'b0;
          res.next_pc = pc;
          res.status  = ST_BADFUNC;
        end
      end
      OP_IMM: begin
        res.wr_en   = 1'b1;
        res.next_pc = pc4;
        if (f3 == F3_ADD) begin
          res.wr_data = x + imm_i;
        end else if (f3 == F3_SRL && instr[31:26] == 6'd0) begin
          res.wr_data = x >> instr[25:20];
        end else begin
          res.wr_en   = 1'b0;
          res.next_pc = pc;
          res.status  = ST_BADFUNC;
        end
      end
      OP_BRANCH: begin
        if (f3 == F3_BLT || f3 == F3_BNE) begin
          // signed compare by flipping the sign bits
          if (f3 == F3_BLT) begin
            take = ({~x[63], x[62:0]} < {~y[63], y[62:0]});
          end else begin
            take = (x != y);
          end
          res.next_pc = take ? (pc + off_b) : pc4;
        end else begin
          res.status = ST_BADFUNC;
        end
      end
      OP_JAL: begin
        res.wr_en   = 1'b1;
        res.wr_data = pc4;
        res.next_pc = pc + off_j;
      end
      OP_JALR: begin
        res.next_pc = x;
      end
      default: begin
        res.status = ST_BADOP;
      end
    endcase
  end

endmodule

@@ rtl/core/rv64_subset_execute.sv @@
// channel | ports                                   | transfer
// --------+-----------------------------------------+----------------------
// in      | in_kind in_instr in_entry_pc in_arg0..3 | in_valid & in_ready
// out     | out_next_pc out_status out_halted       | out_valid & out_ready
//         | out_a0_value                            |
// cfg     | cfg_wdata (stack_top)                   | cfg_we
//
// register operands are read from the register file memory on the input
// transfer edge; the execute stage uses them the next cycle and loads the
// output register, so an item can enter every cycle while the output is not
// stalled (MUL holds the execute stage for its three 32x32 multiplier steps).
// synchronous active-low reset; the register file needs no clearing pass.
// a full output register stalls the execute stage, which stalls the input.
module rv64_subset_execute
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_instr,
  input  logic [63:0] in_entry_pc,
  input  logic [63:0] in_arg0,
  input  logic [63:0] in_arg1,
  input  logic [63:0] in_arg2,
  input  logic [63:0] in_arg3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_next_pc,
  output logic [1:0]  out_status,
  output logic        out_halted,
  output logic [63:0] out_a0_value,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  logic        e_valid_r, e_valid_nxt;
  logic        e_kind_r;
  logic [31:0] e_instr_r;
  xlen_t       e_entry_r, e_arg0_r, e_arg1_r, e_arg2_r, e_arg3_r;
  xlen_t       pc_r, pc_nxt;
  xlen_t       a0_r, a0_nxt;
  xlen_t       stack_top_r;
  logic        out_valid_r, out_valid_nxt;
  xlen_t       out_pc_r, out_a0_r;
  logic [1:0]  out_status_r;
  logic        out_halted_r;

  logic        accept, slot_free, e_done, e_advance, is_start, mul_go, mul_done;
  xlen_t       rs1_val, rs2_val, mul_prod;
  alu_res_t    res;
  rf_wr_t      rf_wr;
  rf_init_t    rf_init;

  assign is_start  = (e_kind_r == KIND_START);
  assign slot_free = !out_valid_r || out_ready;
  assign e_done    = is_start || !res.is_mul || mul_done;
  assign e_advance = e_valid_r && e_done && slot_free;
  assign in_ready  = !e_valid_r || e_advance;
  assign accept    = in_valid && in_ready;
  assign mul_go    = e_valid_r && !is_start && res.is_mul;

  assign rf_wr.en   = e_advance && !is_start && res.wr_en;
  assign rf_wr.addr = e_instr_r[11:7];
  assign rf_wr.data = res.wr_data;

  assign rf_init.sp = stack_top_r;
  assign rf_init.a0 = e_arg0_r;
  assign rf_init.a1 = e_arg1_r;
  assign rf_init.a2 = e_arg2_r;
  assign rf_init.a3 = e_arg3_r;

  rvx_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .raddr1 (in_instr[19:15]),
    .raddr2 (in_instr[24:20]),
    .wr     (rf_wr),
    .start  (e_advance && is_start),
    .init   (rf_init),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val)
  );

  rvx_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .clr   (e_advance),
    .a     (rs1_val),
    .b     (rs2_val),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rvx_alu u_alu (
    .instr    (e_instr_r),
    .x        (rs1_val),
    .y        (rs2_val),
    .pc       (pc_r),
    .mul_prod (mul_prod),
    .res      (res)
  );

  always_comb begin
    e_valid_nxt = e_valid_r;
    if (accept) begin
      e_valid_nxt = 1'b1;
    end else if (e_advance) begin
      e_valid_nxt = 1'b0;
    end

    pc_nxt = pc_r;
    a0_nxt = a0_r;
    if (e_advance) begin
      if (is_start) begin
        pc_nxt = e_entry_r;
        a0_nxt = e_arg0_r;
      end else begin
        pc_nxt = res.next_pc;
        if (rf_wr.en && rf_wr.addr == REG_A0) begin
          a0_nxt = rf_wr.data;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (e_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      pc_r        <= '0;
      a0_r        <= '0;
      stack_top_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      e_valid_r   <= e_valid_nxt;
      pc_r        <= pc_nxt;
      a0_r        <= a0_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        stack_top_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_kind_r  <= in_kind;
      e_instr_r <= in_instr;
      e_entry_r <= in_entry_pc;
      e_arg0_r  <= in_arg0;
      e_arg1_r  <= in_arg1;
      e_arg2_r  <= in_arg2;
      e_arg3_r  <= in_arg3;
    end
    if (e_advance) begin
      out_pc_r     <= pc_nxt;
      out_status_r <= is_start ? ST_OK : res.status;
      out_halted_r <= (pc_nxt == '0);
      out_a0_r     <= a0_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_next_pc  = out_pc_r;
  assign out_status   = out_status_r;
  assign out_halted   = out_halted_r;
  assign out_a0_value = out_a0_r;

endmodule
